>>> design/mma_pkg.sv
// ----------------------------------------------------------------------------
// mma_pkg
// Shared constants, codes and controller/datapath interface types for the
// matrix multiply-accumulate core.
// ----------------------------------------------------------------------------
`default_nettype none

package mma_pkg;

    localparam int DIM       = 8;
    localparam int IDX_W     = $clog2(DIM);
    localparam int CELLS     = DIM * DIM;
    localparam int ADDR_W    = $clog2(CELLS);
    localparam int FIELD_W   = 3;            // row/col port width
    localparam int AB_W      = 32;           // Q16.16
    localparam int C_W       = 64;           // Q48.16
    localparam int FRAC_BITS = 16;

    typedef enum logic [1:0] {
        OP_LOAD_A  = 2'd0,
        OP_LOAD_B  = 2'd1,
        OP_LOAD_C  = 2'd2,
        OP_COMPUTE = 2'd3
    } op_t;

    // controller -> datapath
    typedef struct packed {
        logic             load_a;
        logic             load_b;
        logic             load_c;
        logic             issue;    // one multiply-add enters the pipe
        logic             first;    // k == 0: start from stored C
        logic             lastk;    // k == DIM-1: element complete
        logic             last;     // final element of the matrix
        logic [IDX_W-1:0] i;
        logic [IDX_W-1:0] j;
        logic [IDX_W-1:0] k;
    } mma_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic pipe_busy;
    } mma_status_t;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [IDX_W-1:0] r,
                                                    input logic [IDX_W-1:0] c);
        return ADDR_W'(int'(r) * DIM + int'(c));
    endfunction

endpackage

`default_nettype wire

>>> design/matrix_multiply_accumulate_core.sv
// ----------------------------------------------------------------------------
// matrix_multiply_accumulate_core
// 8x8 fixed-point matrix multiply-accumulate, C += A * B, with element loads.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: a transfer happens at a rising edge with start high and
//   busy low. op selects load A, load B, load C (row, col, value) or compute.
//   A and B take the low 32 bits of value as Q16.16; C takes all 64 bits as
//   Q48.16. A load with row or col outside the matrix is dropped.
//   Loads never raise busy, so they run back to back.
//   A compute raises busy while 512 multiply-adds are issued one per cycle
//   through the single shared multiplier and while they drain through the
//   three pipeline stages (RAM read, multiply, shift-accumulate).
//   Results: every updated C element is shown for one cycle with out_valid
//   high, row-major, last set on the final one. The receiver cannot stall;
//   each strobe is a completed transfer. Updated C is written back.
//   Reset clears the sequencer and the pipeline valids; the element stores
//   are not cleared and must be loaded before a compute reads them.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix_multiply_accumulate_core
    import mma_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [1:0]            op,
    input  wire logic [FIELD_W-1:0]    row,
    input  wire logic [FIELD_W-1:0]    col,
    input  wire logic signed [C_W-1:0] value,
    output logic                       out_valid,
    output logic [FIELD_W-1:0]         out_row,
    output logic [FIELD_W-1:0]         out_col,
    output logic signed [C_W-1:0]      out_value,
    output logic                       last
);

    mma_cmd_t    cmd;
    mma_status_t status;

    // sequencer: decodes commands and walks i, j, k
    mma_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .op     (op),
        .busy   (busy),
        .cmd    (cmd),
        .status (status)
    );

    // stores, MAC pipeline and result register
    mma_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .row       (row),
        .col       (col),
        .value     (value),
        .out_valid (out_valid),
        .out_row   (out_row),
        .out_col   (out_col),
        .out_value (out_value),
        .last      (last)
    );

endmodule

`default_nettype wire

>>> design/mma_ram.sv
// ----------------------------------------------------------------------------
// mma_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module mma_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> design/mma_ctrl.sv
// ----------------------------------------------------------------------------
// mma_ctrl
// Command decode and i/j/k sequencer for the compute sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module mma_ctrl
    import mma_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [1:0]  op,
    output logic             busy,
    output mma_cmd_t         cmd,
    input  wire mma_status_t status
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_RUN   = 3'b010,
        ST_DRAIN = 3'b100
    } state_t;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] i_reg, i_next;
    logic [IDX_W-1:0] j_reg, j_next;
    logic [IDX_W-1:0] k_reg, k_next;

    logic take;
    logic k_end, j_end, i_end;

    assign take  = start && (state_reg == ST_IDLE);
    assign k_end = (k_reg == IDX_W'(DIM - 1));
    assign j_end = (j_reg == IDX_W'(DIM - 1));
    assign i_end = (i_reg == IDX_W'(DIM - 1));
    assign busy  = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;

        cmd        = '0;
        cmd.i      = i_reg;
        cmd.j      = j_reg;
        cmd.k      = k_reg;
        cmd.first  = (k_reg == '0);
        cmd.lastk  = k_end;
        cmd.last   = i_end && j_end;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    unique case (op_t'(op))
                        OP_LOAD_A:  cmd.load_a = 1'b1;
                        OP_LOAD_B:  cmd.load_b = 1'b1;
                        OP_LOAD_C:  cmd.load_c = 1'b1;
                        OP_COMPUTE:
                        begin
                            state_next = ST_RUN;
                            i_next     = '0;
                            j_next     = '0;
                            k_next     = '0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_RUN:
            begin
                cmd.issue = 1'b1;
                k_next    = k_end ? '0 : k_reg + 1'b1;
                if (k_end)
                begin
                    j_next = j_end ? '0 : j_reg + 1'b1;
                    if (j_end)
                    begin
                        i_next = i_end ? '0 : i_reg + 1'b1;
                        if (i_end)
                        begin
                            state_next = ST_DRAIN;
                        end
                    end
                end
            end
            ST_DRAIN:
            begin
                if (!status.pipe_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
        end
    end

endmodule

`default_nettype wire

>>> design/mma_datapath.sv
// ----------------------------------------------------------------------------
// mma_datapath
// Element stores, multiply stage, shift-accumulate stage, C write-back and
// the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mma_datapath
    import mma_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire mma_cmd_t            cmd,
    output mma_status_t              status,
    input  wire logic [FIELD_W-1:0]  row,
    input  wire logic [FIELD_W-1:0]  col,
    input  wire logic signed [C_W-1:0] value,
    output logic                     out_valid,
    output logic [FIELD_W-1:0]       out_row,
    output logic [FIELD_W-1:0]       out_col,
    output logic signed [C_W-1:0]    out_value,
    output logic                     last
);

    // load addressing
    logic              in_range;
    logic [ADDR_W-1:0] load_addr;

    assign in_range  = (32'(row) < DIM) && (32'(col) < DIM);
    assign load_addr = cell_addr(IDX_W'(row), IDX_W'(col));

    // stage 1: RAM outputs
    logic             s1_valid_reg;
    logic             s1_first_reg, s1_lastk_reg, s1_last_reg;
    logic [IDX_W-1:0] s1_i_reg, s1_j_reg;
    logic [AB_W-1:0]  a_rdata, b_rdata;
    logic [C_W-1:0]   c_rdata;

    // stage 2: product
    logic                  s2_valid_reg;
    logic                  s2_first_reg, s2_lastk_reg, s2_last_reg;
    logic [IDX_W-1:0]      s2_i_reg, s2_j_reg;
    logic signed [C_W-1:0] prod_reg;
    logic [C_W-1:0]        c_hold_reg;
    logic [C_W-1:0]        acc_reg;

    logic signed [C_W-1:0] prod_next;
    logic [C_W-1:0]        addend;
    logic [C_W-1:0]        acc_next;

    // result register
    logic                  out_valid_reg;
    logic [FIELD_W-1:0]    out_row_reg, out_col_reg;
    logic [C_W-1:0]        out_value_reg;
    logic                  last_reg;

    logic              c_we;
    logic [ADDR_W-1:0] c_waddr;
    logic [C_W-1:0]    c_wdata;
    logic              wb;

    assign wb      = s2_valid_reg && s2_lastk_reg;
    assign c_we    = (cmd.load_c && in_range) || wb;
    assign c_waddr = wb ? cell_addr(s2_i_reg, s2_j_reg) : load_addr;
    assign c_wdata = wb ? acc_next : value;

    mma_ram #(.WIDTH(AB_W), .DEPTH(CELLS)) u_ram_a (
        .clk   (clk),
        .we    (cmd.load_a && in_range),
        .waddr (load_addr),
        .wdata (value[AB_W-1:0]),
        .re    (cmd.issue),
        .raddr (cell_addr(cmd.i, cmd.k)),
        .rdata (a_rdata)
    );

    mma_ram #(.WIDTH(AB_W), .DEPTH(CELLS)) u_ram_b (
        .clk   (clk),
        .we    (cmd.load_b && in_range),
        .waddr (load_addr),
        .wdata (value[AB_W-1:0]),
        .re    (cmd.issue),
        .raddr (cell_addr(cmd.k, cmd.j)),
        .rdata (b_rdata)
    );

    mma_ram #(.WIDTH(C_W), .DEPTH(CELLS)) u_ram_c (
        .clk   (clk),
        .we    (c_we),
        .waddr (c_waddr),
        .wdata (c_wdata),
        .re    (cmd.issue && cmd.first),
        .raddr (cell_addr(cmd.i, cmd.j)),
        .rdata (c_rdata)
    );

    // exact 64-bit product, then arithmetic shift to Q48.16; sum wraps
    assign prod_next = C_W'(signed'(a_rdata)) * C_W'(signed'(b_rdata));
    assign addend    = C_W'(prod_reg >>> FRAC_BITS);
    assign acc_next  = (s2_first_reg ? c_hold_reg : acc_reg) + addend;

    assign status.pipe_busy = s1_valid_reg || s2_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= cmd.issue;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= wb;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_first_reg <= cmd.first;
        s1_lastk_reg <= cmd.lastk;
        s1_last_reg  <= cmd.last;
        s1_i_reg     <= cmd.i;
        s1_j_reg     <= cmd.j;

        s2_first_reg <= s1_first_reg;
        s2_lastk_reg <= s1_lastk_reg;
        s2_last_reg  <= s1_last_reg;
        s2_i_reg     <= s1_i_reg;
        s2_j_reg     <= s1_j_reg;
        prod_reg     <= prod_next;
        if (s1_valid_reg && s1_first_reg)
        begin
            c_hold_reg <= c_rdata;
        end

        if (s2_valid_reg)
        begin
            acc_reg <= acc_next;
        end

        if (wb)
        begin
            out_row_reg   <= FIELD_W'(s2_i_reg);
            out_col_reg   <= FIELD_W'(s2_j_reg);
            out_value_reg <= acc_next;
            last_reg      <= s2_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;
    assign out_value = signed'(out_value_reg);
    assign last      = last_reg;

endmodule

`default_nettype wire

>>> verif/mma_checker.sv
// ----------------------------------------------------------------------------
// mma_checker
// Watches the command and result channels of the matrix multiply-accumulate
// core, keeps its own copy of the A, B and C stores, predicts every updated
// C element on compute and compares each result strobe in order.
// ----------------------------------------------------------------------------
`default_nettype none

module mma_checker
    import mma_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic                  busy,
    input  wire logic [1:0]            op,
    input  wire logic [FIELD_W-1:0]    row,
    input  wire logic [FIELD_W-1:0]    col,
    input  wire logic signed [C_W-1:0] value,
    input  wire logic                  out_valid,
    input  wire logic [FIELD_W-1:0]    out_row,
    input  wire logic [FIELD_W-1:0]    out_col,
    input  wire logic signed [C_W-1:0] out_value,
    input  wire logic                  last,
    output int                         fail_count,
    output int                         pending,
    output int                         results_seen
);

    typedef struct packed {
        logic [FIELD_W-1:0] r;
        logic [FIELD_W-1:0] c;
        logic [C_W-1:0]     v;
        logic               fin;
    } c_elem_t;

    logic [AB_W-1:0] a_store [CELLS];
    logic [AB_W-1:0] b_store [CELLS];
    logic [C_W-1:0]  c_store [CELLS];

    c_elem_t c_updates_due [$];
    int      fails;
    int      seen;

    // Q16.16 x Q16.16, floor-shifted back to Q48.16
    function automatic logic [C_W-1:0] q16_product(input logic [AB_W-1:0] x,
                                                   input logic [AB_W-1:0] y);
        logic signed [C_W-1:0] xs;
        logic signed [C_W-1:0] ys;
        logic signed [C_W-1:0] p;
        xs = {{(C_W-AB_W){x[AB_W-1]}}, x};
        ys = {{(C_W-AB_W){y[AB_W-1]}}, y};
        p  = xs * ys;
        return p >>> FRAC_BITS;
    endfunction

    task automatic run_gemm_update();
        logic [C_W-1:0] acc;
        c_elem_t        elem;
        for (int i = 0; i < DIM; i++)
        begin
            for (int j = 0; j < DIM; j++)
            begin
                acc = c_store[i*DIM + j];
                for (int k = 0; k < DIM; k++)
                    acc += q16_product(a_store[i*DIM + k], b_store[k*DIM + j]);
                c_store[i*DIM + j] = acc;
                elem.r   = FIELD_W'(i);
                elem.c   = FIELD_W'(j);
                elem.v   = acc;
                elem.fin = (i == DIM-1) && (j == DIM-1);
                c_updates_due.push_back(elem);
            end
        end
    endtask

    task automatic check_result();
        c_elem_t want;
        seen++;
        if (c_updates_due.size() == 0)
        begin
            fails++;
            if (fails <= 10)
                $display("unexpected result: row %0d col %0d value %h last %b",
                         out_row, out_col, out_value, last);
            return;
        end
        want = c_updates_due.pop_front();
        if (want.r !== out_row || want.c !== out_col || want.v !== out_value
            || want.fin !== last)
        begin
            fails++;
            if (fails <= 10)
                $display({"mismatch on result %0d: expected r%0d c%0d %h last %b,",
                          " got r%0d c%0d %h last %b"},
                         seen, want.r, want.c, want.v, want.fin,
                         out_row, out_col, out_value, last);
        end
    endtask

    task automatic apply_command();
        int idx;
        idx = int'(row) * DIM + int'(col);
        case (op)
            OP_LOAD_A:  a_store[idx] = value[AB_W-1:0];
            OP_LOAD_B:  b_store[idx] = value[AB_W-1:0];
            OP_LOAD_C:  c_store[idx] = value;
            OP_COMPUTE: run_gemm_update();
            default:    ;
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_updates_due.delete();
            fails        = 0;
            seen         = 0;
            fail_count   <= 0;
            pending      <= 0;
            results_seen <= 0;
        end
        else
        begin
            if (out_valid)
                check_result();
            if (start && !busy)
                apply_command();
            fail_count   <= fails;
            pending      <= c_updates_due.size();
            results_seen <= seen;
        end
    end

endmodule

`default_nettype wire

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the matrix multiply-accumulate core. Fills every
// store entry, runs a directed set of corner values and computes, then three
// random phases with different sender idle rates; mma_checker does the
// prediction and comparison.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

    import mma_pkg::*;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    op_t                   op = OP_LOAD_A;
    logic [FIELD_W-1:0]    row = '0;
    logic [FIELD_W-1:0]    col = '0;
    logic signed [C_W-1:0] value = '0;
    logic                  out_valid;
    logic [FIELD_W-1:0]    out_row;
    logic [FIELD_W-1:0]    out_col;
    logic signed [C_W-1:0] out_value;
    logic                  last;

    int fail_count;
    int pending;
    int results_seen;

    // command bookkeeping for the closing summary
    int cmds_sent;
    int computes_sent;

    always #2 clk = ~clk;

    matrix_multiply_accumulate_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .op        (op),
        .row       (row),
        .col       (col),
        .value     (value),
        .out_valid (out_valid),
        .out_row   (out_row),
        .out_col   (out_col),
        .out_value (out_value),
        .last      (last)
    );

    mma_checker chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .op           (op),
        .row          (row),
        .col          (col),
        .value        (value),
        .out_valid    (out_valid),
        .out_row      (out_row),
        .out_col      (out_col),
        .out_value    (out_value),
        .last         (last),
        .fail_count   (fail_count),
        .pending      (pending),
        .results_seen (results_seen)
    );

    // One command transfer. Called right after a rising edge; the fields go
    // out by NBA in that step. busy read just after the edge is the value the
    // core sampled, so the loop exits on the edge that took the transfer.
    // With gap == 0 start simply stays high for the next command.
    task automatic send_cmd(input op_t o, input logic [FIELD_W-1:0] r,
                            input logic [FIELD_W-1:0] c, input logic [C_W-1:0] v,
                            input int gap);
        start <= 1'b1;
        op    <= o;
        row   <= r;
        col   <= c;
        value <= v;
        do
            @(posedge clk);
        while (busy);
        cmds_sent++;
        if (o == OP_COMPUTE)
            computes_sent++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Hold the sender off until every predicted C element has come out.
    // The first edge lets the checker's count pick up a compute that was
    // just transferred; the tail covers the pipeline after the last strobe.
    task automatic wait_all_results();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (16) @(posedge clk);
    endtask

    // Mix of fully random words, the signed extremes, small Q16.16 values
    // and random upper halves (ignored for A and B loads).
    function automatic logic [C_W-1:0] pick_value();
        logic [AB_W-1:0] lo;
        case ($urandom_range(0, 5))
            0: return {$urandom, $urandom};
            1: return 64'h7FFF_FFFF_FFFF_FFFF;
            2: return 64'h8000_0000_0000_0000;
            3:
            begin
                lo = $urandom & 32'h0003_FFFF;
                if ($urandom_range(0, 1))
                    lo = -lo;
                return {{32{lo[31]}}, lo};
            end
            4: return {$urandom, 32'hFFFF_FFFF};
            default: return {$urandom, $urandom & 32'h8001_FFFF};
        endcase
    endfunction

    // Random phase: mostly loads with random content, about one in eight a
    // compute. Computes carry random row/col/value, which the core ignores.
    // Each cycle the sender could offer is left idle with chance idle_pct.
    task automatic random_phase(input int n_items, input int idle_pct);
        op_t o;
        int  gap;
        for (int n = 0; n < n_items; n++)
        begin
            if ($urandom_range(0, 99) < 12)
                o = OP_COMPUTE;
            else
                o = op_t'($urandom_range(0, 2));
            gap = 0;
            while ($urandom_range(0, 99) < idle_pct)
                gap++;
            send_cmd(o, FIELD_W'($urandom), FIELD_W'($urandom), pick_value(), gap);
        end
    endtask

    // Run-time limit, far above the slowest legal run.
    initial
    begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        cmds_sent     = 0;
        computes_sent = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The stores come up undefined: write every A, B and C entry before
        // the first compute so no read ever hits an unwritten cell.
        for (int r = 0; r < DIM; r++)
            for (int c = 0; c < DIM; c++)
            begin
                send_cmd(OP_LOAD_A, FIELD_W'(r), FIELD_W'(c), pick_value(), 0);
                send_cmd(OP_LOAD_B, FIELD_W'(r), FIELD_W'(c), pick_value(), 0);
                send_cmd(OP_LOAD_C, FIELD_W'(r), FIELD_W'(c), pick_value(), 0);
            end

        // Directed: Q16.16 extremes with junk in the upper half, -1 lsb to
        // exercise floor rounding, C near both signed limits to force wrap,
        // corner cells, a compute with garbage fields, back-to-back computes.
        send_cmd(OP_LOAD_A, 3'd0, 3'd0, 64'hDEAD_BEEF_7FFF_FFFF, 0);
        send_cmd(OP_LOAD_A, 3'd0, 3'd1, 64'h0000_0000_8000_0000, 0);
        send_cmd(OP_LOAD_A, 3'd0, 3'd2, 64'h0000_0000_FFFF_FFFF, 0);
        send_cmd(OP_LOAD_B, 3'd0, 3'd0, 64'h0000_0000_7FFF_FFFF, 0);
        send_cmd(OP_LOAD_B, 3'd1, 3'd0, 64'hFFFF_FFFF_8000_0000, 0);
        send_cmd(OP_LOAD_B, 3'd2, 3'd0, 64'h0000_0000_0001_0000, 0);
        send_cmd(OP_LOAD_B, 3'd7, 3'd7, 64'h1234_5678_8000_0000, 0);
        send_cmd(OP_LOAD_A, 3'd7, 3'd7, 64'h0000_0000_8000_0000, 0);
        send_cmd(OP_LOAD_C, 3'd0, 3'd0, 64'h7FFF_FFFF_FFFF_FFFF, 0);
        send_cmd(OP_LOAD_C, 3'd7, 3'd7, 64'h8000_0000_0000_0000, 0);
        send_cmd(OP_LOAD_C, 3'd0, 3'd7, 64'h0000_0000_0000_0000, 0);
        send_cmd(OP_COMPUTE, 3'd7, 3'd5, 64'hFFFF_FFFF_FFFF_FFFF, 0);
        send_cmd(OP_LOAD_A, 3'd7, 3'd7, 64'h0, 0);
        send_cmd(OP_LOAD_C, 3'd3, 3'd4, 64'hFFFF_FFFF_FFFF_FFFF, 0);
        send_cmd(OP_COMPUTE, 3'd0, 3'd0, 64'h0, 0);
        send_cmd(OP_COMPUTE, 3'd2, 3'd6, 64'h5555_AAAA_5555_AAAA, 3);
        send_cmd(OP_LOAD_A, 3'd1, 3'd1, 64'h0000_0000_0000_0001, 0);
        send_cmd(OP_LOAD_B, 3'd1, 3'd1, 64'hFFFF_FFFF_FFFF_FFFF, 0);
        send_cmd(OP_COMPUTE, 3'd1, 3'd1, 64'h0, 0);
        wait_all_results();

        // Random phases: light sender idling, heavy idling, then none.
        random_phase(10, 22);
        wait_all_results();
        random_phase(10, 64);
        wait_all_results();
        random_phase(10, 0);
        wait_all_results();

        $display("Covered %0d command transfers, %0d of them computes; %0d C elements checked",
                 cmds_sent, computes_sent, results_seen);
        $display("over full store fill, corner values and three sender idle profiles.");
        if (fail_count == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire
